[hw/rtl/aesctr_pkg.sv]
// Package: shared types, constants and the AES xtime helper function for the CTR engine.
package aesctr_pkg;

    localparam int NUM_ROUNDS = 10;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [63:0] text_high;
        logic [63:0] text_low;
        logic [4:0]  valid_bytes;
        logic [63:0] block_number;
    } t_req;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  result_bytes;
    } t_rsp;

    typedef struct packed {
        logic [127:0] state;
        logic [127:0] rkey;
        logic [127:0] text;
        logic [4:0]   nbytes;
    } t_stage;

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

[hw/rtl/aesctr_round.sv]
// One registered AES round stage with its on-the-fly round key expansion.
module aesctr_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  aesctr_pkg::t_stage    i_stage,
    input  logic [7:0]            i_rcon,
    input  logic                  i_last,
    output logic                  o_valid,
    output aesctr_pkg::t_stage    o_stage
);
    import aesctr_pkg::*;

    logic [7:0]   s  [16];
    logic [7:0]   sb [16];
    logic [7:0]   mc [16];
    logic [127:0] mc_vec;
    logic [31:0]  w  [4];
    logic [31:0]  nw [4];
    logic [31:0]  sub_w;
    logic [127:0] nkey;
    logic         r_valid;
    t_stage       r_stage;
    t_stage       n_stage;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_stage.state[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[4*c + r] = SBOX[s[4*((c + r) % 4) + r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] t;
            t = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
            if (i_last) begin
                mc[4*c]   = sb[4*c];
                mc[4*c+1] = sb[4*c+1];
                mc[4*c+2] = sb[4*c+2];
                mc[4*c+3] = sb[4*c+3];
            end else begin
                mc[4*c]   = sb[4*c]   ^ t ^ xtime(sb[4*c]   ^ sb[4*c+1]);
                mc[4*c+1] = sb[4*c+1] ^ t ^ xtime(sb[4*c+1] ^ sb[4*c+2]);
                mc[4*c+2] = sb[4*c+2] ^ t ^ xtime(sb[4*c+2] ^ sb[4*c+3]);
                mc[4*c+3] = sb[4*c+3] ^ t ^ xtime(sb[4*c+3] ^ sb[4*c]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            mc_vec[127 - 8*i -: 8] = mc[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w[i] = i_stage.rkey[127 - 32*i -: 32];
        end
        sub_w = {SBOX[w[3][23:16]] ^ i_rcon, SBOX[w[3][15:8]],
                 SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        nw[0] = w[0] ^ sub_w;
        nw[1] = w[1] ^ nw[0];
        nw[2] = w[2] ^ nw[1];
        nw[3] = w[3] ^ nw[2];
        nkey  = {nw[0], nw[1], nw[2], nw[3]};
    end

    always_comb begin
        n_stage        = i_stage;
        n_stage.rkey   = nkey;
        n_stage.state  = mc_vec ^ nkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

[hw/rtl/aes128_counter_mode_block.sv]
// Top level: AES-128 counter-mode engine, one block per cycle unless the receiver stalls, 12-stage pipeline.
// Usage:
//   Requests enter on i_valid/o_ready with payload i_req: 16 data bytes, the
//   valid byte count and the block index. The counter block is eight zero
//   bytes followed by the index, big-endian; it is encrypted with AES-128 and
//   XORed into the valid data bytes, other bytes come out zero.
//   Responses leave on o_valid/i_ready with payload o_rsp.
//   The key is written through i_cfg_we/i_cfg_idx/i_cfg_data (index 0 key
//   bytes 0..7, index 1 bytes 8..15) while no request is in flight.
//   The pipeline has one input stage, ten round stages and one output
//   stage. Each round stage carries its own round key, derived from the
//   previous stage's, so a new request is taken every cycle unless stalled.
//   Reset clears all stage valid bits and the key to zero.
//   When the receiver stalls, the whole pipeline holds; o_ready drops
//   only while the output register is full and not being taken.
module aes128_counter_mode_block (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  aesctr_pkg::t_req   i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output aesctr_pkg::t_rsp   o_rsp,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);
    import aesctr_pkg::*;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        en;
    logic        r_in_valid;
    t_stage      r_in_stage;
    logic        v   [NUM_ROUNDS + 1];
    t_stage      stg [NUM_ROUNDS + 1];
    logic        r_out_valid;
    t_rsp        r_out;
    t_rsp        n_out;
    logic [127:0] res;

    assign en = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_stage.state  <= {64'd0, i_req.block_number} ^ {r_key_high, r_key_low};
            r_in_stage.rkey   <= {r_key_high, r_key_low};
            r_in_stage.text   <= {i_req.text_high, i_req.text_low};
            r_in_stage.nbytes <= i_req.valid_bytes;
        end
    end

    assign v[0]   = r_in_valid;
    assign stg[0] = r_in_stage;

    for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
        aesctr_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[k]),
            .i_stage (stg[k]),
            .i_rcon  (RCON[k]),
            .i_last  (k == NUM_ROUNDS - 1),
            .o_valid (v[k+1]),
            .o_stage (stg[k+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            res[127 - 8*i -: 8] = (stg[NUM_ROUNDS].nbytes > 5'(i))
                ? (stg[NUM_ROUNDS].text[127 - 8*i -: 8] ^ stg[NUM_ROUNDS].state[127 - 8*i -: 8])
                : 8'h00;
        end
        n_out.result_high  = res[127:64];
        n_out.result_low   = res[63:0];
        n_out.result_bytes = stg[NUM_ROUNDS].nbytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v[NUM_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.result_bytes == 5'd0 |->
            o_rsp.result_high == 64'd0 && o_rsp.result_low == 64'd0)
        else $error("bytes beyond zero count not cleared");

    a_short_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.result_bytes < 5'd9 |-> o_rsp.result_low == 64'd0)
        else $error("low half not cleared for short block");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(v[NUM_ROUNDS]) && $stable(r_in_valid))
        else $error("pipeline moved while stalled");
endmodule

[test/testbench.sv]
// Testbench for the AES-128 counter-mode engine: directed and random requests checked against a local cipher model.
module testbench;
    import aesctr_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_req        i_req;
    logic        o_valid;
    logic        i_ready;
    t_rsp        o_rsp;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;

    aes128_counter_mode_block uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam logic [7:0] SB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    localparam logic [7:0] RC [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };
    localparam int LATENCY = 12;
    localparam longint CYCLE_LIMIT = 400000;

    logic [63:0] key_hi_model;
    logic [63:0] key_lo_model;
    t_req        pending_reqs[$];
    t_rsp        expected_rsps[$];
    logic        stim_done;
    logic        req_taken;
    int          mismatches;
    longint      cycle_count;
    int          burst_left;
    int          gap_left;
    int          hold_off;
    int          stall_phase;

    function automatic void add_pending(input t_req rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    function automatic void add_expected(input t_rsp rs);
        expected_rsps.insert(expected_rsps.size(), rs);
    endfunction

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // keystream block for a given index under the current key
    function automatic logic [127:0] ctr_keystream(input logic [63:0] idx);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tb [16];
        logic [7:0] t [4];
        logic [7:0] x, a0, a1, a2, a3, s;
        logic [127:0] key, blk;
        key = {key_hi_model, key_lo_model};
        for (int i = 0; i < 16; i++) rk[i] = key[127 - 8*i -: 8];
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) t[j] = rk[4*(i-1) + j];
            if (i % 4 == 0) begin
                x = t[0];
                t[0] = SB[t[1]] ^ RC[i/4 - 1];
                t[1] = SB[t[2]];
                t[2] = SB[t[3]];
                t[3] = SB[x];
            end
            for (int j = 0; j < 4; j++) rk[4*i + j] = rk[4*(i-4) + j] ^ t[j];
        end
        blk = {64'd0, idx};
        for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++) tb[4*c + w] = SB[st[4*((c + w) % 4) + w]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = tb[4*c]; a1 = tb[4*c+1]; a2 = tb[4*c+2]; a3 = tb[4*c+3];
                    s = a0 ^ a1 ^ a2 ^ a3;
                    tb[4*c]   = a0 ^ s ^ gmul2(a0 ^ a1);
                    tb[4*c+1] = a1 ^ s ^ gmul2(a1 ^ a2);
                    tb[4*c+2] = a2 ^ s ^ gmul2(a2 ^ a3);
                    tb[4*c+3] = a3 ^ s ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tb[i] ^ rk[16*r + i];
        end
        for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = st[i];
        return blk;
    endfunction

    function automatic t_rsp ctr_crypt(input t_req rq);
        logic [127:0] ks, data, res;
        int n;
        t_rsp rs;
        n = (rq.valid_bytes > 16) ? 16 : rq.valid_bytes;
        ks = ctr_keystream(rq.block_number);
        data = {rq.text_high, rq.text_low};
        for (int i = 0; i < 16; i++)
            res[127 - 8*i -: 8] = (i < n) ? (data[127 - 8*i -: 8] ^ ks[127 - 8*i -: 8]) : 8'h00;
        rs.result_high = res[127:64];
        rs.result_low = res[63:0];
        rs.result_bytes = rq.valid_bytes;
        return rs;
    endfunction

    function automatic t_req rand_req(input int vb);
        t_req rq;
        rq.text_high = {$urandom, $urandom};
        rq.text_low = {$urandom, $urandom};
        rq.valid_bytes = 5'(vb);
        case ($urandom_range(3))
            0: rq.block_number = 64'(($urandom_range(40)));
            1: rq.block_number = {$urandom, $urandom};
            2: rq.block_number = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(5);
            default: rq.block_number = {32'd0, $urandom};
        endcase
        return rq;
    endfunction

    task automatic write_key(input logic idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KEY_HIGH) key_hi_model = val;
        else key_lo_model = val;
    endtask

    task automatic drain_pipe();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || i_valid)
            @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_KEY_HIGH;
        i_cfg_data = '0;
        key_hi_model = '0;
        key_lo_model = '0;
        stim_done = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key, directed corners
        for (int vb = 0; vb < 32; vb += (vb < 17 ? 1 : 7)) add_pending(rand_req(vb));
        begin
            t_req rq;
            rq = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16,
                   64'hFFFF_FFFF_FFFF_FFFF};
            add_pending(rq);
            rq = '{64'd0, 64'd0, 5'd16, 64'd0};
            add_pending(rq);
        end
        drain_pipe();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_key(CFG_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
                    write_key(CFG_KEY_LOW, 64'habf7_1588_09cf_4f3c);
                end
                1: begin
                    write_key(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
                    write_key(CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
                end
                2: begin
                    write_key(CFG_KEY_HIGH, 64'd0);
                    write_key(CFG_KEY_LOW, 64'd0);
                end
                default: begin
                    write_key(CFG_KEY_HIGH, {$urandom, $urandom});
                    write_key(CFG_KEY_LOW, {$urandom, $urandom});
                end
            endcase
            for (int k = 0; k < 310; k++)
                add_pending(rand_req(($urandom_range(9) == 0) ?
                    $urandom_range(31) : (($urandom_range(3) == 0) ? $urandom_range(1, 15) : 16)));
            drain_pipe();
        end
        stim_done = 1'b1;
    end

    // request driver: bursts with gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_req <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                i_valid <= 1'b1;
                i_req <= pending_reqs.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    initial i_valid = 1'b0;
    initial i_req = '0;
    initial i_ready = 1'b0;

    // receiver stall pattern plus occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_off <= 0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_ready <= 1'b0;
            end else if (stall_phase % 700 == 300) begin
                hold_off <= 60;
                i_ready <= 1'b0;
            end else if ((stall_phase / 128) % 3 == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mismatches <= 0;
            cycle_count <= 0;
            req_taken <= 1'b0;
        end else begin
            cycle_count <= cycle_count + 1;
            req_taken <= i_valid && o_ready;
            if (i_valid && o_ready) add_expected(ctr_crypt(i_req));
            if (o_valid && i_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected response %h", o_rsp);
                end else begin
                    t_rsp want;
                    want = expected_rsps.pop_front();
                    if (want.result_high !== o_rsp.result_high
                        || want.result_low !== o_rsp.result_low
                        || want.result_bytes !== o_rsp.result_bytes) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp %h %h %0d got %h %h %0d",
                                want.result_high, want.result_low, want.result_bytes,
                                o_rsp.result_high, o_rsp.result_low, o_rsp.result_bytes);
                    end
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        @(posedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/aesctr_pkg.sv
hw/rtl/aesctr_round.sv
hw/rtl/aes128_counter_mode_block.sv
test/testbench.sv
